FILE: rtl/heading_turn_controller_macros.svh
// heading_turn_controller_macros.svh: assertion macros for the heading turn controller.
// Used by the port checker; no dependencies.
`ifndef HEADING_TURN_CONTROLLER_MACROS_SVH
`define HEADING_TURN_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset
`define HTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/htc_pkg.sv
// htc_pkg.sv: types and constants shared by the heading turn controller modules.
// No dependencies.
`default_nettype none

package htc_pkg;

  // Field widths
  localparam int AngleW  = 16;
  localparam int GainW   = 16;
  localparam int WeightW = 4;
  localparam int DriveW  = 8;
  localparam int CountW  = 4;
  localparam int DiffW   = 17;  // target - heading
  localparam int WrapW   = 18;  // difference with the +-360 degree candidate
  localparam int EmagW   = 16;  // |error|, at most 29535
  localparam int ProdW   = 31;  // gain * |error| < 2^31
  localparam int QuotW   = 18;  // product / 9000 < 2^18
  localparam int RemW    = 14;  // division remainder, below 9000
  localparam int PmagW   = 19;  // |p| after the static offset
  localparam int CfgIdxW = 2;

  // Serial unit step counts
  localparam int MulSteps = GainW;
  localparam int DivSteps = QuotW;

  // Arithmetic constants (hundredths of a degree, Q.10 drive)
  localparam logic [WrapW-1:0]   WrapSpan   = 18'd36000;
  localparam logic [RemW:0]      DivConst   = 15'd9000;
  localparam logic [9:0]         OffsetBase = 10'd123;
  localparam logic [5:0]         OffsetStep = 6'd51;
  localparam logic [6:0]         DriveMax   = 7'd127;
  localparam logic [EmagW-1:0]   ErrDead    = 16'd15;
  localparam logic [EmagW-1:0]   ErrTol     = 16'd20;
  localparam logic [CountW-1:0]  CountMax   = 4'd15;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET = 2'd0,
    CFG_GAIN   = 2'd1,
    CFG_WEIGHT = 2'd2
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } htc_state_t;

endpackage

`default_nettype wire

FILE: rtl/htc_mul.sv
// htc_mul.sv: bit-serial shift-add multiplier, one gain bit per cycle.
// Depends on htc_pkg.
`default_nettype none

module htc_mul (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [htc_pkg::EmagW-1:0]     mcand,
  input  wire [htc_pkg::GainW-1:0]     mplier,
  output logic                         done,
  output logic [htc_pkg::ProdW-1:0]    product
);

  localparam int CntW = $clog2(htc_pkg::MulSteps);
  localparam logic [CntW-1:0] LastStep = CntW'(htc_pkg::MulSteps - 1);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CntW-1:0]              cnt_r, cnt_nxt;
  logic [htc_pkg::EmagW-1:0]    mcand_r, mcand_nxt;
  logic [htc_pkg::EmagW-1:0]    hi_r, hi_nxt;
  logic [htc_pkg::GainW-1:0]    lo_r, lo_nxt;
  logic [htc_pkg::EmagW:0]      sum;

  // One partial product per cycle: add when the low multiplier bit is set
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      mcand_nxt = mcand;
      hi_nxt    = '0;
      lo_nxt    = mplier;
    end else if (busy_r) begin
      hi_nxt  = sum[htc_pkg::EmagW:1];
      lo_nxt  = {sum[0], lo_r[htc_pkg::GainW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LastStep) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
  end

  assign done    = done_r;
  assign product = htc_pkg::ProdW'({hi_r, lo_r});

endmodule

`default_nettype wire

FILE: rtl/htc_div.sv
// htc_div.sv: bit-serial restoring divider by the constant 9000, one quotient bit per cycle.
// Depends on htc_pkg.
`default_nettype none

module htc_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [htc_pkg::ProdW-1:0]     dividend,
  output logic                         done,
  output logic [htc_pkg::QuotW-1:0]    quotient
);

  localparam int CntW = $clog2(htc_pkg::DivSteps);
  localparam logic [CntW-1:0] LastStep = CntW'(htc_pkg::DivSteps - 1);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CntW-1:0]              cnt_r, cnt_nxt;
  logic [htc_pkg::RemW-1:0]     rem_r, rem_nxt;
  logic [htc_pkg::QuotW-1:0]    sh_r, sh_nxt;
  logic [htc_pkg::RemW:0]       cand;
  logic [htc_pkg::RemW:0]       diff;
  logic                         ge;

  // Trial subtract on the remainder with the next dividend bit shifted in
  assign cand = {rem_r, sh_r[htc_pkg::QuotW-1]};
  assign ge   = (cand >= htc_pkg::DivConst);
  assign diff = cand - htc_pkg::DivConst;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    if (start) begin
      // top bits of the dividend are below 9000, so they seed the remainder
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = htc_pkg::RemW'(dividend[htc_pkg::ProdW-1:htc_pkg::QuotW]);
      sh_nxt   = dividend[htc_pkg::QuotW-1:0];
    end else if (busy_r) begin
      rem_nxt = ge ? diff[htc_pkg::RemW-1:0] : cand[htc_pkg::RemW-1:0];
      sh_nxt  = {sh_r[htc_pkg::QuotW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LastStep) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Remainder and quotient shift registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign done     = done_r;
  assign quotient = sh_r;

endmodule

`default_nettype wire

FILE: rtl/heading_turn_controller.sv
// heading_turn_controller.sv: top level, sequencer, wrap/error front end and drive output.
// Depends on htc_pkg, htc_mul and htc_div.
//
// One heading sample in, one drive beat out. From acceptance to the output register a
// sample passes these steps: the difference is registered at acceptance, the
// shortest-wrap error is formed, the bit-serial gain multiplier runs and hands off,
// the bit-serial divide-by-9000 runs and hands off while adding the static offset,
// and the result saturates into the output register. One sample is in flight at a
// time, so a new sample is not taken before the current one is through. The next is
// taken once the current one has reached the output register, even if that beat has
// not yet been taken. Config writes are always ready, and every write to a listed
// register restarts the settle count.
`default_nettype none

module heading_turn_controller #(
  parameter int SETTLE_SAMPLES = 10
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // sample channel
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire signed [htc_pkg::AngleW-1:0] in_heading,
  // result channel
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [htc_pkg::DriveW-1:0] out_left_drive,
  output logic signed [htc_pkg::DriveW-1:0] out_right_drive,
  output logic                           out_settled,
  // config channel
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [htc_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire [htc_pkg::AngleW-1:0]      cfg_data
);

  localparam logic [htc_pkg::CountW-1:0] SettleLimit = htc_pkg::CountW'(SETTLE_SAMPLES);

  htc_pkg::htc_state_t state_r, state_nxt;

  // config registers
  logic [htc_pkg::AngleW-1:0]   target_r, target_nxt;
  logic [htc_pkg::GainW-1:0]    gain_r, gain_nxt;
  logic [htc_pkg::WeightW-1:0]  weight_r, weight_nxt;

  // turn state
  logic [htc_pkg::CountW-1:0]   cnt_r, cnt_nxt;
  logic                         done_flag_r, done_flag_nxt;

  // per-sample datapath
  logic [htc_pkg::DiffW-1:0]    d_r, d_nxt;
  logic                         e_neg_r, e_neg_nxt;
  logic                         e_le_tol_r, e_le_tol_nxt;
  logic                         e_gt_dead_r, e_gt_dead_nxt;
  logic [htc_pkg::PmagW-1:0]    p_mag_r, p_mag_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [htc_pkg::DriveW-1:0]   left_r, left_nxt;
  logic [htc_pkg::DriveW-1:0]   right_r, right_nxt;
  logic                         settled_r, settled_nxt;

  // sequencer controls
  logic in_beat, cfg_beat, mul_start, div_start, fin_load;

  // serial units
  logic                         mul_done, div_done;
  logic [htc_pkg::ProdW-1:0]    product;
  logic [htc_pkg::QuotW-1:0]    quotient;

  // wrap front end
  logic signed [htc_pkg::WrapW-1:0] d_ext, w_val;
  logic [htc_pkg::DiffW-1:0]    d_abs, w_abs, e_abs;
  logic                         w_pick;
  logic [htc_pkg::EmagW-1:0]    e_mag;

  // offset and drive
  logic [9:0]                   offset;
  logic                         p_big;
  logic [6:0]                   big_mag;
  logic [15:0]                  small_prod;
  logic [6:0]                   drive_mag;
  logic [htc_pkg::DriveW-1:0]   drive;
  logic [htc_pkg::CountW-1:0]   cnt_upd;
  logic                         finish_now;

  assign in_beat  = in_valid && in_ready;
  assign cfg_beat = cfg_valid && cfg_ready;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      htc_pkg::ST_IDLE: if (in_valid) state_nxt = htc_pkg::ST_WRAP;
      htc_pkg::ST_WRAP: state_nxt = htc_pkg::ST_MUL;
      htc_pkg::ST_MUL:  if (mul_done) state_nxt = htc_pkg::ST_DIV;
      htc_pkg::ST_DIV:  if (div_done) state_nxt = htc_pkg::ST_FIN;
      htc_pkg::ST_FIN:  if (!out_valid_r || out_ready) state_nxt = htc_pkg::ST_IDLE;
      default:          state_nxt = htc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    fin_load  = 1'b0;
    unique case (state_r)
      htc_pkg::ST_IDLE: in_ready  = 1'b1;
      htc_pkg::ST_WRAP: mul_start = 1'b1;
      htc_pkg::ST_MUL:  div_start = mul_done;
      htc_pkg::ST_DIV:  ;
      htc_pkg::ST_FIN:  fin_load  = !out_valid_r || out_ready;
      default:          ;
    endcase
  end

  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- config writes
  always_comb begin
    target_nxt = target_r;
    gain_nxt   = gain_r;
    weight_nxt = weight_r;
    if (cfg_beat) begin
      unique case (cfg_index)
        htc_pkg::CFG_TARGET: target_nxt = cfg_data;
        htc_pkg::CFG_GAIN:   gain_nxt   = cfg_data;
        htc_pkg::CFG_WEIGHT: weight_nxt = cfg_data[htc_pkg::WeightW-1:0];
        default:             ;
      endcase
    end
  end

  // ---------------------------------------------------------------- wrap front end
  // difference taken at acceptance
  assign d_nxt = in_beat
      ? htc_pkg::DiffW'($signed({target_r[htc_pkg::AngleW-1], target_r})
                        - $signed({in_heading[htc_pkg::AngleW-1], in_heading}))
      : d_r;

  // the other candidate is one full turn away, toward zero
  assign d_ext  = htc_pkg::WrapW'($signed(d_r));
  assign w_val  = ($signed(d_r) > 0) ? d_ext - $signed(htc_pkg::WrapSpan)
                                     : d_ext + $signed(htc_pkg::WrapSpan);
  assign d_abs  = d_r[htc_pkg::DiffW-1] ? htc_pkg::DiffW'(-$signed(d_r)) : d_r;
  assign w_abs  = w_val[htc_pkg::WrapW-1] ? htc_pkg::DiffW'(-w_val) : htc_pkg::DiffW'(w_val);
  assign w_pick = d_abs > w_abs;
  assign e_abs  = w_pick ? w_abs : d_abs;
  assign e_mag  = e_abs[htc_pkg::EmagW-1:0];

  always_comb begin
    e_neg_nxt     = e_neg_r;
    e_le_tol_nxt  = e_le_tol_r;
    e_gt_dead_nxt = e_gt_dead_r;
    if (state_r == htc_pkg::ST_WRAP) begin
      e_neg_nxt     = w_pick ? w_val[htc_pkg::WrapW-1] : d_r[htc_pkg::DiffW-1];
      e_le_tol_nxt  = e_mag <= htc_pkg::ErrTol;
      e_gt_dead_nxt = e_mag > htc_pkg::ErrDead;
    end
  end

  // ---------------------------------------------------------------- serial units
  htc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (e_mag),
    .mplier  (gain_r),
    .done    (mul_done),
    .product (product)
  );

  htc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------------------------------------------------------- static offset
  assign offset    = htc_pkg::OffsetBase + 10'(weight_r) * 10'(htc_pkg::OffsetStep);
  assign p_mag_nxt = div_done ? htc_pkg::PmagW'(quotient) + htc_pkg::PmagW'(offset) : p_mag_r;

  // ---------------------------------------------------------------- drive and settle
  assign p_big      = |p_mag_r[htc_pkg::PmagW-1:9];
  assign big_mag    = (p_mag_r[htc_pkg::PmagW-1:4] > 15'(htc_pkg::DriveMax))
                      ? htc_pkg::DriveMax : p_mag_r[10:4];
  // times 127 as shift and subtract, then over 1024
  assign small_prod = {p_mag_r[8:0], 7'd0} - {7'd0, p_mag_r[8:0]};

  assign cnt_upd    = (e_le_tol_r && cnt_r < htc_pkg::CountMax) ? cnt_r + 1'b1 : cnt_r;
  assign finish_now = cnt_upd > SettleLimit;

  always_comb begin
    priority if (done_flag_r || finish_now) drive_mag = '0;
    else if (p_big)                         drive_mag = big_mag;
    else if (e_gt_dead_r)                   drive_mag = {1'b0, small_prod[15:10]};
    else                                    drive_mag = '0;
  end

  assign drive = e_neg_r ? htc_pkg::DriveW'(-$signed({1'b0, drive_mag}))
                         : {1'b0, drive_mag};

  always_comb begin
    cnt_nxt       = cnt_r;
    done_flag_nxt = done_flag_r;
    if (cfg_beat && (cfg_index == htc_pkg::CFG_TARGET || cfg_index == htc_pkg::CFG_GAIN ||
                     cfg_index == htc_pkg::CFG_WEIGHT)) begin
      cnt_nxt       = '0;
      done_flag_nxt = 1'b0;
    end else if (fin_load && !done_flag_r) begin
      cnt_nxt       = cnt_upd;
      done_flag_nxt = finish_now;
    end
  end

  // ---------------------------------------------------------------- output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    settled_nxt   = settled_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (fin_load) begin
      out_valid_nxt = 1'b1;
      left_nxt      = drive;
      right_nxt     = htc_pkg::DriveW'(-$signed(drive));
      settled_nxt   = done_flag_r || finish_now;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htc_pkg::ST_IDLE;
      target_r    <= '0;
      gain_r      <= htc_pkg::GainW'(256);
      weight_r    <= '0;
      cnt_r       <= '0;
      done_flag_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      target_r    <= target_nxt;
      gain_r      <= gain_nxt;
      weight_r    <= weight_nxt;
      cnt_r       <= cnt_nxt;
      done_flag_r <= done_flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    d_r         <= d_nxt;
    e_neg_r     <= e_neg_nxt;
    e_le_tol_r  <= e_le_tol_nxt;
    e_gt_dead_r <= e_gt_dead_nxt;
    p_mag_r     <= p_mag_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    settled_r   <= settled_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_left_drive  = left_r;
  assign out_right_drive = right_r;
  assign out_settled     = settled_r;

endmodule

`default_nettype wire

FILE: rtl/htc_checker.sv
// htc_checker.sv: port-level checker for heading_turn_controller, bound to the top level.
// Depends on htc_pkg and heading_turn_controller_macros.svh.
`default_nettype none

`include "heading_turn_controller_macros.svh"

module htc_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [htc_pkg::DriveW-1:0]    out_left_drive,
  input wire [htc_pkg::DriveW-1:0]    out_right_drive,
  input wire                          out_settled
);

  // sides always mirror each other
  `HTC_ASSERT_NOW(a_mirror, clk, rst_n, out_valid,
    out_right_drive == htc_pkg::DriveW'(-$signed(out_left_drive)), "sides not mirrored")

  // a settled beat carries no drive
  `HTC_ASSERT_NOW(a_settled_zero, clk, rst_n, out_valid && out_settled,
    out_left_drive == '0, "drive while settled")

  // drive stays within saturation limits
  `HTC_ASSERT_NOW(a_sat, clk, rst_n, out_valid,
    out_left_drive != 8'h80, "drive out of range")

  // a stalled result beat holds
  `HTC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_left_drive) && $stable(out_settled), "stalled beat changed")

  // the serial datapath holds one sample at a time: no sample accepted right after another
  `HTC_ASSERT_NEXT(a_spacing, clk, rst_n, in_valid && in_ready,
    !in_ready, "sample accepted on consecutive cycles")

endmodule

bind heading_turn_controller htc_checker u_htc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_left_drive  (out_left_drive),
  .out_right_drive (out_right_drive),
  .out_settled     (out_settled)
);

`default_nettype wire

FILE: bench/heading_turn_controller_tb.sv
// heading_turn_controller_tb.sv: self-checking bench for the heading turn controller.
// Depends on htc_pkg and heading_turn_controller; predicts every drive beat in-bench.
`timescale 1ns / 1ps

module heading_turn_controller_tb;

  localparam int    SettleSamples = 10;
  localparam int    MaxIdle       = 11;
  localparam int    HoldCycles    = 400;
  localparam int    DrainCycles   = 60;
  localparam int    CycleLimit    = 500000;
  localparam int    PrintLimit    = 40;
  // heading arithmetic, hundredths of a degree and Q.10
  localparam longint FullTurn     = 36000;
  localparam longint GainDiv      = 9000;
  localparam longint OffsBase     = 123;
  localparam longint OffsStep     = 51;
  localparam longint HalfDrive    = 512;
  localparam longint DeadBand     = 15;
  localparam longint TolBand      = 20;
  localparam longint DriveLim     = 127;
  localparam logic [htc_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic signed [htc_pkg::DriveW-1:0] left;
    logic signed [htc_pkg::DriveW-1:0] right;
    logic                              settled;
  } drive_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [htc_pkg::AngleW-1:0] in_heading;
  logic out_valid;
  logic out_ready;
  logic signed [htc_pkg::DriveW-1:0] out_left_drive;
  logic signed [htc_pkg::DriveW-1:0] out_right_drive;
  logic out_settled;
  logic cfg_valid;
  logic cfg_ready;
  logic [htc_pkg::CfgIdxW-1:0] cfg_index;
  logic [htc_pkg::AngleW-1:0] cfg_data;

  // bench copy of the controller's registers and turn state
  logic signed [htc_pkg::AngleW-1:0] tgt_angle;
  logic [htc_pkg::GainW-1:0]         kp_gain;
  logic [htc_pkg::WeightW-1:0]       wt_adjust;
  logic [htc_pkg::CountW-1:0]        in_tol_count;
  logic                              turn_done;

  drive_beat_t pending_drive_q[$];
  int mismatch_count = 0;
  int beat_count = 0;
  int cycle_count = 0;
  int tx_max_gap = MaxIdle;
  int rx_max_stall = MaxIdle;
  int rx_hold = 0;

  heading_turn_controller #(.SETTLE_SAMPLES(SettleSamples)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_heading(in_heading),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_left_drive(out_left_drive), .out_right_drive(out_right_drive),
    .out_settled(out_settled),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint mag_of(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clamp_drive(input longint v);
    if (v > DriveLim) return DriveLim;
    if (v < -DriveLim) return -DriveLim;
    return v;
  endfunction

  // Predicted drive beat for one accepted heading; advances the turn state
  function automatic drive_beat_t next_drive(input logic signed [htc_pkg::AngleW-1:0] heading);
    longint diff, wrapped, err, prop, offs, drv, neg;
    drive_beat_t beat;
    diff    = longint'(tgt_angle) - longint'(heading);
    wrapped = (tgt_angle > heading) ? diff - FullTurn : diff + FullTurn;
    err     = (mag_of(diff) > mag_of(wrapped)) ? wrapped : diff;
    drv     = 0;
    if (!turn_done) begin
      prop = kp_gain;
      prop = (prop * err) / GainDiv;
      offs = wt_adjust;
      offs = OffsBase + OffsStep * offs;
      prop = (err < 0) ? prop - offs : prop + offs;
      if (mag_of(prop) >= HalfDrive)
        drv = clamp_drive(prop / 16);
      else if (mag_of(err) > DeadBand)
        drv = clamp_drive((prop * 127) / 1024);
      if (mag_of(err) <= TolBand && in_tol_count < htc_pkg::CountMax)
        in_tol_count = in_tol_count + 1'b1;
      // the sample that finishes the turn already carries zero drive
      if (in_tol_count > SettleSamples) begin
        turn_done = 1'b1;
        drv = 0;
      end
    end
    neg          = -drv;
    beat.left    = drv[htc_pkg::DriveW-1:0];
    beat.right   = neg[htc_pkg::DriveW-1:0];
    beat.settled = turn_done;
    return beat;
  endfunction

  // Register write as the block sees it; listed registers restart the turn
  function automatic void apply_reg(input logic [htc_pkg::CfgIdxW-1:0] idx,
                                    input logic [htc_pkg::AngleW-1:0] data);
    case (idx)
      htc_pkg::CFG_TARGET: tgt_angle = data;
      htc_pkg::CFG_GAIN:   kp_gain = data;
      htc_pkg::CFG_WEIGHT: wt_adjust = data[htc_pkg::WeightW-1:0];
      default:             return;
    endcase
    in_tol_count = '0;
    turn_done = 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PrintLimit)
      $display("mismatch at beat %0d: %s got %0d, expected %0d", beat_count, what, got, want);
  endtask

  // Sends one heading beat after a random gap; valid stays up for a back-to-back beat
  task automatic send_heading(input logic signed [htc_pkg::AngleW-1:0] heading);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_heading <= heading;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_drive_q.push_back(next_drive(heading));
  endtask

  task automatic write_reg(input logic [htc_pkg::CfgIdxW-1:0] idx,
                           input logic [htc_pkg::AngleW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering beats and wait until every predicted beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Receiver: random stall before each beat, or a long hold when one is requested
  initial begin : drive_sink
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, rx_max_stall);
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Compare each drive beat with the oldest prediction
  always @(posedge clk) begin : drive_check
    drive_beat_t want;
    if (rst_n === 1'b1 && out_valid && out_ready) begin
      beat_count++;
      if (pending_drive_q.size() == 0) begin
        report_mismatch("unexpected beat, left_drive", out_left_drive, 0);
      end else begin
        want = pending_drive_q.pop_front();
        if (out_left_drive !== want.left)
          report_mismatch("left_drive", out_left_drive, want.left);
        if (out_right_drive !== want.right)
          report_mismatch("right_drive", out_right_drive, want.right);
        if (out_settled !== want.settled)
          report_mismatch("settled", out_settled, want.settled);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("heading_turn_controller_tb NOT OK");
    $finish;
  end

  // Field extremes, wrap-around error and the dead band under several settings
  task automatic test_extremes();
    send_heading(16'sd32767);
    send_heading(-16'sd32768);
    send_heading(16'sd18000);
    send_heading(-16'sd18000);
    send_heading(16'sd21);
    send_heading(-16'sd21);
    send_heading(16'sd15);
    send_heading(-16'sd20);
    drain_results();
    write_reg(htc_pkg::CFG_TARGET, 16'h7fff);
    write_reg(htc_pkg::CFG_GAIN, 16'hffff);
    write_reg(htc_pkg::CFG_WEIGHT, 16'h000f);
    send_heading(-16'sd32768);
    send_heading(16'sd32767);
    send_heading(16'sd0);
    drain_results();
    write_reg(htc_pkg::CFG_TARGET, 16'h8000);
    write_reg(htc_pkg::CFG_GAIN, 16'h0000);
    write_reg(htc_pkg::CFG_WEIGHT, 16'hfff0);
    send_heading(16'sd5000);
    send_heading(-16'sd32768);
  endtask

  // Turn completion: eleven samples within tolerance, hold after done, restart
  task automatic test_settle();
    drain_results();
    write_reg(htc_pkg::CFG_TARGET, 16'd1000);
    write_reg(htc_pkg::CFG_GAIN, 16'd512);
    write_reg(htc_pkg::CFG_WEIGHT, 16'd3);
    send_heading(16'sd1000);
    send_heading(16'sd1020);
    send_heading(16'sd980);
    send_heading(16'sd4000);
    send_heading(16'sd1015);
    send_heading(16'sd990);
    send_heading(16'sd1005);
    send_heading(16'sd1000);
    send_heading(16'sd995);
    send_heading(16'sd1010);
    send_heading(16'sd1001);
    send_heading(-16'sd30000);
    send_heading(16'sd1002);
    send_heading(-16'sd2000);
    // unlisted index leaves the finished turn alone
    drain_results();
    write_reg(CfgUnused, 16'hffff);
    send_heading(16'sd5000);
    drain_results();
    write_reg(htc_pkg::CFG_WEIGHT, 16'd5);
    send_heading(16'sd1000);
  endtask

  // Phases of random settings and headings, mostly close to the target
  task automatic test_random_phases(input int item_total);
    int sent, phase_len, offs;
    logic signed [htc_pkg::AngleW-1:0] heading;
    logic [htc_pkg::AngleW-1:0] data;
    sent = 0;
    while (sent < item_total) begin
      drain_results();
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 4))
          0:       data = 16'h8000;
          1:       data = 16'h7fff;
          2:       data = 16'($urandom());
          default: data = 16'(int'($urandom_range(0, 36000)) - 18000);
        endcase
        write_reg(htc_pkg::CFG_TARGET, data);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0:       data = 16'h0000;
          1:       data = 16'hffff;
          2:       data = 16'($urandom());
          default: data = 16'($urandom_range(0, 1024));
        endcase
        write_reg(htc_pkg::CFG_GAIN, data);
      end
      if ($urandom_range(0, 1))
        write_reg(htc_pkg::CFG_WEIGHT, 16'($urandom()));
      if ($urandom_range(0, 7) == 0)
        write_reg(CfgUnused, 16'($urandom()));
      tx_max_gap   = ($urandom_range(0, 2) == 0) ? 0 : MaxIdle;
      rx_max_stall = ($urandom_range(0, 2) == 0) ? 0 : MaxIdle;
      phase_len = $urandom_range(15, 60);
      repeat (phase_len) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: offs = int'($urandom_range(0, 60)) - 30;
          5, 6:          offs = int'($urandom_range(0, 800)) - 400;
          default:       offs = int'($urandom());
        endcase
        heading = 16'(int'(tgt_angle) + offs);
        send_heading(heading);
        sent++;
      end
    end
  endtask

  // Long receiver hold while beats keep coming, so the input stalls
  task automatic test_backpressure();
    drain_results();
    tx_max_gap = 0;
    rx_max_stall = MaxIdle;
    rx_hold = HoldCycles;
    repeat (10) send_heading(16'(tgt_angle + 16'(int'($urandom_range(0, 80)) - 40)));
  endtask

  initial begin : main_seq
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_heading <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= htc_pkg::CFG_TARGET;
    cfg_data   <= '0;
    tgt_angle    = '0;
    kp_gain      = 16'd256;
    wt_adjust    = '0;
    in_tol_count = '0;
    turn_done    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_settle();
    test_backpressure();
    test_random_phases(560);

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (pending_drive_q.size() != 0)
      report_mismatch("beats missing", 0, pending_drive_q.size());
    if (mismatch_count == 0) begin
      $display("heading_turn_controller_tb OK");
    end else begin
      $display("heading_turn_controller_tb NOT OK");
    end
    $finish;
  end

endmodule
